/* rtl/sts_pkg.sv */
// shared constants, types and helper functions of the sine series unit
`default_nettype none

package sts_pkg;

  // default configuration
  localparam int TERMS_DEFAULT           = 5;
  localparam int ANGLE_FRAC_BITS_DEFAULT = 24;
  localparam int OUT_FRAC_BITS_DEFAULT   = 30;

  // working precision of the series (Q30)
  localparam int WORK_FRAC = 30;

  // pi with 62 fraction bits
  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

  // round(2^32 / (m(m+1))) for m = 2, 4, ..., 16
  localparam logic [31:0] RECIP_Q32 [8] = '{
    32'd715827883, 32'd214748365, 32'd102261126, 32'd59652324,
    32'd39045157,  32'd27531842,  32'd20452225,  32'd15790321
  };

  // request travelling through the remainder chain
  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
  } red_t;

  // request travelling through the series chain
  typedef struct packed {
    logic [31:0]        x2;
    logic [30:0]        term;
    logic signed [32:0] sum;
    logic               neg;
  } ser_t;

  // pi scaled down by sh bits, rounded to nearest
  function automatic logic [63:0] angle_const(input int sh);
    logic [64:0] v;
    v = {1'b0, PI_Q62} + (65'd1 << (sh - 1));
    return 64'(v >> sh);
  endfunction

endpackage

`default_nettype wire

/* rtl/sts_reduce_cell.sv */
// one restoring step of the remainder by 2*pi
`default_nettype none

module sts_reduce_cell
  import sts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] step,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire red_t        in_pl,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      red_t        out_pl
);

  logic vld;
  red_t pl;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_pl    = pl;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  // conditional subtract of this step's multiple
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pl.neg <= in_pl.neg;
      if (in_pl.mag >= step) begin
        pl.mag <= in_pl.mag - step;
      end else begin
        pl.mag <= in_pl.mag;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sts_term_cell.sv */
// one series term: multiply by x^2, scale by the reciprocal, accumulate
`default_nettype none

module sts_term_cell
  import sts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] recip,
  input  wire logic        subtract,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire ser_t        in_pl,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      ser_t        out_pl
);

  localparam logic [62:0] RND_A = 63'd1 << (WORK_FRAC - 1);
  localparam logic [64:0] RND_B = 65'd1 << 31;

  logic               a_vld;
  logic               a_rdy;
  logic [31:0]        a_x2;
  logic signed [32:0] a_sum;
  logic               a_neg;
  logic [32:0]        a_prod;

  logic               b_vld;
  logic               b_rdy;
  ser_t               b_pl;

  logic [62:0]        mul_a;
  logic [62:0]        rnd_a;
  logic signed [32:0] term_ext;
  logic signed [32:0] sum_a;
  logic [64:0]        mul_b;
  logic [64:0]        rnd_b;

  assign a_rdy     = !a_vld || b_rdy;
  assign b_rdy     = !b_vld || out_ready;
  assign in_ready  = a_rdy;
  assign out_valid = b_vld;
  assign out_pl    = b_pl;

  // first half: term times x^2, and the current term folded into the sum
  assign mul_a    = 63'(in_pl.term) * 63'(in_pl.x2);
  assign rnd_a    = mul_a + RND_A;
  assign term_ext = $signed({2'b00, in_pl.term});
  assign sum_a    = subtract ? (in_pl.sum - term_ext) : (in_pl.sum + term_ext);

  // second half: scale by 1/(m(m+1))
  assign mul_b = 65'(a_prod) * 65'(recip);
  assign rnd_b = mul_b + RND_B;

  // occupancy of both halves
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld <= in_valid;
      end
      if (b_rdy) begin
        b_vld <= a_vld;
      end
    end
  end

  // first half registers
  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_x2   <= in_pl.x2;
      a_sum  <= sum_a;
      a_neg  <= in_pl.neg;
      a_prod <= rnd_a[62:WORK_FRAC];
    end
  end

  // second half registers
  always_ff @(posedge clk) begin
    if (a_vld && b_rdy) begin
      b_pl.x2   <= a_x2;
      b_pl.sum  <= a_sum;
      b_pl.neg  <= a_neg;
      b_pl.term <= rnd_b[62:32];
    end
  end

endmodule

`default_nettype wire

/* rtl/sine_taylor_series_unit.sv */
// top level of the sine series unit: range reduction, series chain, output
`default_nettype none

// Sine of a signed fixed-point angle (ANGLE_FRAC_BITS fraction bits) with
// OUT_FRAC_BITS fraction bits, saturated to plus or minus one. The unit is a
// fully pipelined chain: one angle is taken and one sine given in every
// cycle while the output is not stalled. QBITS = 29 - ANGLE_FRAC_BITS is the
// number of restoring steps of the remainder by 2*pi; each series term has
// two register halves, one per multiplier. Every stage holds its own request,
// so the input keeps flowing into empty stages while a finished sine waits
// on a stalled output.
module sine_taylor_series_unit
  import sts_pkg::*;
#(
  parameter int TERMS           = TERMS_DEFAULT,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEFAULT,
  parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        angle_valid,
  output      logic        angle_stall,
  input  wire logic [31:0] angle,
  output      logic        sine_valid,
  input  wire logic        sine_stall,
  output      logic [31:0] sine
);

  localparam int QBITS = 29 - ANGLE_FRAC_BITS;
  localparam int SHIFT = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int SH    = WORK_FRAC - OUT_FRAC_BITS;

  localparam logic [63:0] PI_W      = angle_const(62 - ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO_PI_W  = angle_const(61 - ANGLE_FRAC_BITS);
  localparam logic [63:0] HALF_PI_W = angle_const(63 - ANGLE_FRAC_BITS);
  localparam logic [31:0] PI_C      = PI_W[31:0];
  localparam logic [31:0] TWO_PI_C  = TWO_PI_W[31:0];
  localparam logic [31:0] HALF_PI_C = HALF_PI_W[31:0];

  localparam logic [32:0] RND = (33'd1 << SH) >> 1;
  localparam logic [32:0] ONE = 33'd1 << OUT_FRAC_BITS;

  // input stage
  logic        in_vld;
  logic        in_rdy;
  logic [31:0] in_mag;
  logic        in_neg;
  logic [31:0] abs_w;

  // remainder chain
  red_t           red_pl [QBITS + 1];
  logic [QBITS:0] red_v;
  logic [QBITS:0] red_r;

  // folding stages
  logic        wr_vld;
  logic        wr_rdy;
  logic [31:0] wr_ang;
  logic [31:0] wrap_w;

  logic        hf_vld;
  logic        hf_rdy;
  logic [31:0] hf_ang;
  logic        hf_sgn;

  logic        fd_vld;
  logic        fd_rdy;
  logic [30:0] fd_x;
  logic        fd_sgn;
  logic [31:0] fold_w;

  // square stage
  logic        sq_vld;
  logic        sq_rdy;
  ser_t        sq_pl;
  logic [61:0] sq_w;
  logic [61:0] sq_rnd;

  // series chain
  ser_t           ser_pl [TERMS + 1];
  logic [TERMS:0] ser_v;
  logic [TERMS:0] ser_r;

  // final sum and output
  logic               sm_vld;
  logic               sm_rdy;
  logic [31:0]        sm_val;
  logic               sm_neg;
  logic signed [32:0] last_ext;
  logic signed [32:0] fin_w;

  logic               out_vld;
  logic               out_rdy;
  logic [32:0]        rnd_w;
  logic [32:0]        mag_w;
  logic [32:0]        sat_w;
  logic [32:0]        res_w;

  // input stage: magnitude and sign of the angle
  assign abs_w       = angle[31] ? (~angle + 32'd1) : angle;
  assign in_rdy      = !in_vld || red_r[0];
  assign angle_stall = !in_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_rdy) begin
      in_vld <= angle_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (angle_valid && in_rdy) begin
      in_mag <= abs_w;
      in_neg <= angle[31];
    end
  end

  // remainder of the magnitude by 2*pi, largest multiple first
  assign red_pl[0] = '{mag: in_mag, neg: in_neg};
  assign red_v[0]  = in_vld;

  for (genvar i = 0; i < QBITS; i++) begin : g_red
    localparam logic [31:0] STEP = TWO_PI_C << (QBITS - 1 - i);
    sts_reduce_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (STEP),
      .in_valid  (red_v[i]),
      .in_ready  (red_r[i]),
      .in_pl     (red_pl[i]),
      .out_valid (red_v[i+1]),
      .out_ready (red_r[i+1]),
      .out_pl    (red_pl[i+1])
    );
  end

  assign red_r[QBITS] = wr_rdy;

  // negative angles wrap into [0, 2*pi)
  assign wrap_w = (red_pl[QBITS].neg && (red_pl[QBITS].mag != 32'd0)) ?
                  (TWO_PI_C - red_pl[QBITS].mag) : red_pl[QBITS].mag;
  assign wr_rdy = !wr_vld || hf_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_vld <= 1'b0;
    end else if (wr_rdy) begin
      wr_vld <= red_v[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (red_v[QBITS] && wr_rdy) begin
      wr_ang <= wrap_w;
    end
  end

  // lower half-turn, recording the sign
  assign hf_rdy = !hf_vld || fd_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      hf_vld <= 1'b0;
    end else if (hf_rdy) begin
      hf_vld <= wr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_vld && hf_rdy) begin
      if (wr_ang >= PI_C) begin
        hf_ang <= wr_ang - PI_C;
        hf_sgn <= 1'b1;
      end else begin
        hf_ang <= wr_ang;
        hf_sgn <= 1'b0;
      end
    end
  end

  // fold into the first quadrant and move to Q30
  always_comb begin
    if (hf_ang > PI_C) begin
      fold_w = 32'd0;
    end else if (hf_ang >= HALF_PI_C) begin
      fold_w = PI_C - hf_ang;
    end else begin
      fold_w = hf_ang;
    end
  end

  assign fd_rdy = !fd_vld || sq_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      fd_vld <= 1'b0;
    end else if (fd_rdy) begin
      fd_vld <= hf_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (hf_vld && fd_rdy) begin
      fd_x   <= 31'(fold_w << SHIFT);
      fd_sgn <= hf_sgn;
    end
  end

  // x squared, and the chain request with the first term
  assign sq_w   = 62'(fd_x) * 62'(fd_x);
  assign sq_rnd = sq_w + (62'd1 << (WORK_FRAC - 1));
  assign sq_rdy = !sq_vld || ser_r[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else if (sq_rdy) begin
      sq_vld <= fd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fd_vld && sq_rdy) begin
      sq_pl.x2   <= sq_rnd[61:WORK_FRAC];
      sq_pl.term <= fd_x;
      sq_pl.sum  <= 33'sd0;
      sq_pl.neg  <= fd_sgn;
    end
  end

  // series cells, one per term
  assign ser_pl[0] = sq_pl;
  assign ser_v[0]  = sq_vld;

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    localparam logic SUB = (k % 2) == 1;
    sts_term_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .recip     (RECIP_Q32[k]),
      .subtract  (SUB),
      .in_valid  (ser_v[k]),
      .in_ready  (ser_r[k]),
      .in_pl     (ser_pl[k]),
      .out_valid (ser_v[k+1]),
      .out_ready (ser_r[k+1]),
      .out_pl    (ser_pl[k+1])
    );
  end

  assign ser_r[TERMS] = sm_rdy;

  // last term into the sum, clamped below at zero
  assign last_ext = $signed({2'b00, ser_pl[TERMS].term});
  assign fin_w    = ((TERMS % 2) == 1) ? (ser_pl[TERMS].sum - last_ext) :
                                         (ser_pl[TERMS].sum + last_ext);
  assign sm_rdy   = !sm_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_vld <= 1'b0;
    end else if (sm_rdy) begin
      sm_vld <= ser_v[TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (ser_v[TERMS] && sm_rdy) begin
      sm_val <= fin_w[32] ? 32'd0 : fin_w[31:0];
      sm_neg <= ser_pl[TERMS].neg;
    end
  end

  // rounding to the output precision, saturation and sign
  assign rnd_w = 33'(sm_val) + RND;
  assign mag_w = rnd_w >> SH;
  assign sat_w = (mag_w > ONE) ? ONE : mag_w;
  assign res_w = sm_neg ? (33'd0 - sat_w) : sat_w;

  assign out_rdy    = !out_vld || !sine_stall;
  assign sine_valid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_rdy) begin
      out_vld <= sm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (sm_vld && out_rdy) begin
      sine <= res_w[31:0];
    end
  end

  // the remainder chain leaves less than one full turn
  a_red_range: assert property (@(posedge clk) disable iff (rst)
    red_v[QBITS] |-> (red_pl[QBITS].mag < TWO_PI_C))
    else $error("remainder not below 2*pi");

  // after the half-turn step the angle is at most pi
  a_half_range: assert property (@(posedge clk) disable iff (rst)
    hf_vld |-> (hf_ang <= PI_C))
    else $error("half-turn step left angle above pi");

  // an empty input stage never stalls the sender
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !in_vld |-> !angle_stall)
    else $error("input stalled with empty input stage");

  // the result never exceeds plus or minus one
  a_out_sat: assert property (@(posedge clk) disable iff (rst)
    sine_valid |-> (($signed(sine) <= $signed(ONE[31:0])) &&
                    ($signed(sine) >= -$signed(ONE[31:0]))))
    else $error("sine beyond plus or minus one");

  // the sum stage moves to the output whenever the output is free
  a_out_move: assert property (@(posedge clk) disable iff (rst)
    (sm_vld && !sine_stall) |=> sine_valid)
    else $error("sum stage did not reach the output");

endmodule

`default_nettype wire

/* tb/tb_sine_taylor_series_unit.sv */
// self-checking testbench of the sine series unit with random traffic and stalls
`timescale 1ns / 100ps
`default_nettype none

module tb_sine_taylor_series_unit;

  localparam int ANGLE_FRAC = 24;

  // pi with 62 fraction bits, and its roundings on the angle's scale
  localparam logic [63:0] PI_FINE  = 64'hC90F_DAA2_2168_C235;
  localparam longint PI_ANG      = longint'((PI_FINE + (64'd1 << (61 - ANGLE_FRAC)))
                                            >> (62 - ANGLE_FRAC));
  localparam longint TWO_PI_ANG  = longint'((PI_FINE + (64'd1 << (60 - ANGLE_FRAC)))
                                            >> (61 - ANGLE_FRAC));
  localparam longint HALF_PI_ANG = longint'((PI_FINE + (64'd1 << (62 - ANGLE_FRAC)))
                                            >> (63 - ANGLE_FRAC));
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct {
    logic [31:0] angle;
    logic [31:0] sine;
  } sine_req_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        angle_valid = 1'b0;
  logic [31:0] angle       = '0;
  logic        sine_stall  = 1'b0;
  logic        angle_stall;
  logic        sine_valid;
  logic [31:0] sine;

  sine_req_t sine_q[$];
  int        errors    = 0;
  int        n_sent    = 0;
  int        n_checked = 0;
  int        n_neg     = 0;
  int        n_sat     = 0;
  int        burst_left = 0;
  int        cyc       = 0;

  sine_taylor_series_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .angle_valid (angle_valid),
    .angle_stall (angle_stall),
    .angle       (angle),
    .sine_valid  (sine_valid),
    .sine_stall  (sine_stall),
    .sine        (sine)
  );

  // clock
  always #10 clk = ~clk;

  // run limit
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  // rounding right shift, half up, on nonnegative values
  function automatic longint unsigned shr_round(input longint unsigned v, input int sh);
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // round(2^32 / (m(m+1))) for m = 2, 4, ...
  function automatic longint unsigned term_recip(input int k);
    case (k & 7)
      0:       return 64'd715827883;
      1:       return 64'd214748365;
      2:       return 64'd102261126;
      3:       return 64'd59652324;
      4:       return 64'd39045157;
      5:       return 64'd27531842;
      6:       return 64'd20452225;
      default: return 64'd15790321;
    endcase
  endfunction

  // expected sine of one angle: fold into [0, pi/2], then the odd series
  function automatic logic [31:0] sine_of(input logic [31:0] ang);
    longint            a;
    bit                neg;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   s;
    longint            sum;
    logic [63:0]       res;
    a   = longint'($signed(ang));
    neg = 1'b0;
    if (a >= TWO_PI_ANG || a <= -TWO_PI_ANG) begin
      a = a % TWO_PI_ANG;
    end
    if (a < 0) begin
      a = a + TWO_PI_ANG;
    end
    if (a >= PI_ANG) begin
      a   = a - PI_ANG;
      neg = 1'b1;
    end
    if (a >= HALF_PI_ANG) begin
      a = PI_ANG - a;
    end
    if (a < 0) begin
      a = 0;
    end
    // series in Q30
    x    = longint'(a) << (30 - ANGLE_FRAC);
    x2   = shr_round(x * x, 30);
    term = x;
    sum  = longint'(x);
    for (int k = 0; k < 5; k++) begin
      term = shr_round(term * x2, 30);
      term = shr_round(term * term_recip(k), 32);
      if ((k & 1) == 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    // saturate to one, then apply the sign
    s = longint'(sum);
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    res = neg ? (64'd0 - s) : s;
    return res[31:0];
  endfunction

  // result side stalls on a pattern that steps through four modes in turn
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      sine_stall <= 1'b0;
    end else begin
      case ((cyc / 512) % 4)
        0:       sine_stall <= 1'b0;
        1:       sine_stall <= ($urandom_range(99, 0) < 25);
        2:       sine_stall <= ($urandom_range(99, 0) < 70);
        default: sine_stall <= ((cyc % 7) < 3);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin : check_sine
    sine_req_t e;
    if (!rst && sine_valid && !sine_stall) begin
      if (sine_q.size() == 0) begin
        $display("%0t: unexpected sine %h, nothing pending", $time, sine);
        errors++;
      end else begin
        e = sine_q.pop_front();
        n_checked++;
        if (e.sine[31]) begin
          n_neg++;
        end
        if (e.sine == 32'h4000_0000 || e.sine == 32'hC000_0000) begin
          n_sat++;
        end
        if (sine !== e.sine) begin
          $display("%0t: sine mismatch for angle %h: expected %h actual %h",
                   $time, e.angle, e.sine, sine);
          errors++;
        end
      end
    end
  end

  // send one angle request; bursts of random length with random gaps between
  task automatic send_angle(input longint a);
    sine_req_t r;
    int        gap;
    angle_valid <= 1'b1;
    angle       <= a[31:0];
    @(posedge clk);
    while (angle_stall) begin
      @(posedge clk);
    end
    r.angle = a[31:0];
    r.sine  = sine_of(a[31:0]);
    sine_q.push_back(r);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 50)
                                               : $urandom_range(16, 1);
      gap = $urandom_range(6, 0);
      if (gap > 0) begin
        angle_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // extremes, fold boundaries and exact multiples
  task automatic test_directed();
    send_angle(0);
    send_angle(1);
    send_angle(-1);
    send_angle(longint'(32'sh7FFF_FFFF));
    send_angle(-longint'(64'h8000_0000));
    send_angle(-longint'(64'h7FFF_FFFF));
    send_angle(HALF_PI_ANG - 1);
    send_angle(HALF_PI_ANG);
    send_angle(HALF_PI_ANG + 1);
    send_angle(PI_ANG - 1);
    send_angle(PI_ANG);
    send_angle(PI_ANG + 1);
    send_angle(PI_ANG + HALF_PI_ANG);
    send_angle(TWO_PI_ANG - 1);
    send_angle(TWO_PI_ANG);
    send_angle(TWO_PI_ANG + 1);
    send_angle(-TWO_PI_ANG);
    send_angle(-TWO_PI_ANG + 1);
    send_angle(-TWO_PI_ANG - 1);
    send_angle(-PI_ANG);
    send_angle(-HALF_PI_ANG);
    send_angle(20 * TWO_PI_ANG);
    send_angle(-20 * TWO_PI_ANG);
    send_angle(20 * TWO_PI_ANG + HALF_PI_ANG);
  endtask

  // any 32-bit pattern
  task automatic test_random_full(input int n);
    for (int i = 0; i < n; i++) begin
      send_angle(longint'($signed($urandom())));
    end
  endtask

  // angles within about one turn either side of zero
  task automatic test_random_turn(input int n);
    longint span;
    span = 2 * TWO_PI_ANG + 32;
    for (int i = 0; i < n; i++) begin
      send_angle(longint'($urandom_range(int'(span), 0)) - (TWO_PI_ANG + 16));
    end
  endtask

  // close to multiples of pi/2 over the whole range
  task automatic test_near_folds(input int n);
    longint k;
    longint off;
    for (int i = 0; i < n; i++) begin
      k   = longint'($urandom_range(162, 0)) - 81;
      off = longint'($urandom_range(128, 0)) - 64;
      send_angle(k * HALF_PI_ANG + off);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_full(480);
    test_random_turn(350);
    test_near_folds(200);
    angle_valid <= 1'b0;
    while (sine_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    $display("%0d angles sent, %0d sines checked (%0d negative, %0d at full scale)",
             n_sent, n_checked, n_neg, n_sat);
    if (errors == 0 && sine_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
